// ===== hw/rtl/ipfg_pkg.sv =====
// Shared types and constants for the injector pulse fuel gauge.
// Used by ipfg_tracker, the top level and the port checker.
`timescale 1ns / 1ps

package ipfg_pkg;

  localparam int unsigned CountW  = 32;
  localparam int unsigned VolumeW = 20;
  localparam int unsigned CoeffW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 120;

  localparam logic [CoeffW-1:0]  CoeffReset   = '0;
  localparam logic [VolumeW-1:0] TankReset    = VolumeW'(18000);
  localparam logic [VolumeW-1:0] ReserveReset = VolumeW'(4000);

  localparam logic [CfgIdxW-1:0] RegCoeff   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTank    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegReserve = 2'd2;

  typedef struct packed {
    logic clear_usage;
    logic line_low;
  } sample_t;

  typedef struct packed {
    logic [CountW-1:0] pulses;
    logic [CountW-1:0] open_total_us;
  } usage_t;

endpackage

// ===== hw/rtl/ipfg_tracker.sv =====
// Injector edge tracker: tick clock, open state, pulse count and open total.
// Depends on ipfg_pkg for sample_t and usage_t.
`timescale 1ns / 1ps

module ipfg_tracker (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  ipfg_pkg::sample_t sample,
  output ipfg_pkg::usage_t  usage_next
);

  localparam logic [ipfg_pkg::CountW-1:0] One = 1;

  logic [ipfg_pkg::CountW-1:0] tick_clock;
  logic [ipfg_pkg::CountW-1:0] open_start;
  logic                        injector_open;
  logic [ipfg_pkg::CountW-1:0] pulse_total;
  logic [ipfg_pkg::CountW-1:0] open_time_sum;

  logic [ipfg_pkg::CountW-1:0] open_start_next;
  logic                        injector_open_next;
  logic [ipfg_pkg::CountW-1:0] pulse_total_next;
  logic [ipfg_pkg::CountW-1:0] open_time_sum_next;

  always_comb begin
    pulse_total_next   = sample.clear_usage ? '0 : pulse_total;
    open_time_sum_next = sample.clear_usage ? '0 : open_time_sum;
    open_start_next    = open_start;
    injector_open_next = injector_open;
    if (sample.line_low && !injector_open) begin
      open_start_next    = tick_clock;
      injector_open_next = 1'b1;
      pulse_total_next   = pulse_total_next + One;
    end else if (!sample.line_low && injector_open) begin
      open_time_sum_next = open_time_sum_next + (tick_clock - open_start);
      injector_open_next = 1'b0;
    end
  end

  assign usage_next.pulses        = pulse_total_next;
  assign usage_next.open_total_us = open_time_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_clock    <= '0;
      open_start    <= '0;
      injector_open <= 1'b0;
      pulse_total   <= '0;
      open_time_sum <= '0;
    end else if (accept) begin
      tick_clock    <= tick_clock + One;
      open_start    <= open_start_next;
      injector_open <= injector_open_next;
      pulse_total   <= pulse_total_next;
      open_time_sum <= open_time_sum_next;
    end
  end

endmodule

// ===== hw/rtl/injector_pulse_fuel_gauge_top.sv =====
// Injector pulse fuel gauge top level: config registers and result pipeline.
// Depends on ipfg_pkg and ipfg_tracker.
//
// Usage:
//   s_axis carries one beat per microsecond tick: tdata[0] is the sampled
//   injector line (1 = pulled low, open), tdata[1] clears pulse count and
//   open total before the sample is applied.
//   m_axis returns one beat per input beat with pulse count, open total,
//   fuel used, fuel left and the reserve flag.
//   The cfg channel writes coefficient (index 0), tank size (1) and
//   reserve level (2); other indexes are ignored. Write only while idle.
// Timing:
//   A result is registered once its input beat is taken: tracker update,
//   32x32 coefficient multiply, then tank subtract and reserve compare,
//   each in its own register stage.
//   One beat per cycle is sustained while m_axis_tready stays high.
// Reset and stall:
//   rst clears tick clock, open state, totals, pipeline and registers to
//   their defaults. When the receiver stalls, stages fill up one by one and
//   s_axis_tready drops only once all three stages hold a beat.
`timescale 1ns / 1ps

module injector_pulse_fuel_gauge_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [0] line_low, [1] clear_usage, [7:2] zero
  input  logic [ipfg_pkg::InDataW-1:0]         s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [31:0] pulses, [63:32] open_total_us, [95:64] used_ml,
  // [115:96] left_ml, [116] on_reserve, [119:117] zero
  output logic [ipfg_pkg::OutDataW-1:0]        m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ipfg_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [ipfg_pkg::CfgDataW-1:0]        cfg_data
);

  localparam int unsigned CW = ipfg_pkg::CountW;
  localparam int unsigned VW = ipfg_pkg::VolumeW;
  localparam int unsigned KW = ipfg_pkg::CoeffW;

  logic [KW-1:0] injector_coeff;
  logic [VW-1:0] tank_capacity_ml;
  logic [VW-1:0] reserve_ml;

  ipfg_pkg::sample_t sample;
  ipfg_pkg::usage_t  usage_next;
  logic              accept;

  logic rdy1, rdy2, rdy3;
  logic v1, v2, v3;

  ipfg_pkg::usage_t p1_usage;
  ipfg_pkg::usage_t p2_usage;
  logic [CW-1:0]    p2_used;
  logic [CW+KW-1:0] product;

  logic [CW-1:0] out_pulses;
  logic [CW-1:0] out_total;
  logic [CW-1:0] out_used;
  logic [VW-1:0] out_left;
  logic          out_reserve;
  logic [VW-1:0] left_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      injector_coeff   <= ipfg_pkg::CoeffReset;
      tank_capacity_ml <= ipfg_pkg::TankReset;
      reserve_ml       <= ipfg_pkg::ReserveReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ipfg_pkg::RegCoeff:   injector_coeff   <= cfg_data[KW-1:0];
        ipfg_pkg::RegTank:    tank_capacity_ml <= cfg_data[VW-1:0];
        ipfg_pkg::RegReserve: reserve_ml       <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  assign sample.line_low    = s_axis_tdata[0];
  assign sample.clear_usage = s_axis_tdata[1];

  assign rdy3          = !v3 || m_axis_tready;
  assign rdy2          = !v2 || rdy3;
  assign rdy1          = !v1 || rdy2;
  assign s_axis_tready = rdy1;
  assign accept        = s_axis_tvalid && rdy1;

  ipfg_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sample     (sample),
    .usage_next (usage_next)
  );

  assign product = {{KW{1'b0}}, p1_usage.open_total_us} * {{CW{1'b0}}, injector_coeff};

  always_comb begin
    if (p2_used >= {{(CW-VW){1'b0}}, tank_capacity_ml}) begin
      left_next = '0;
    end else begin
      left_next = tank_capacity_ml - p2_used[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_usage <= usage_next;
    end
    if (rdy2) begin
      p2_usage <= p1_usage;
      p2_used  <= product[CW+KW-1:KW];
    end
    if (rdy3) begin
      out_pulses  <= p2_usage.pulses;
      out_total   <= p2_usage.open_total_us;
      out_used    <= p2_used;
      out_left    <= left_next;
      out_reserve <= (left_next <= reserve_ml);
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {3'b000, out_reserve, out_left, out_used, out_total, out_pulses};

endmodule

// ===== hw/rtl/ipfg_checker.sv =====
// Port checker for the injector pulse fuel gauge, bound to the top level.
// Depends on ipfg_pkg for port widths.
`timescale 1ns / 1ps

module ipfg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ipfg_pkg::OutDataW-1:0] m_axis_tdata
);

  // Hold a stalled output beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  // Drain the pipeline on reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  // Accept input whenever the output stage is empty.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // No fuel used without open time.
  a_used_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[63:32] == 32'd0) |-> (m_axis_tdata[95:64] == 32'd0))
    else $error("fuel used with zero open time");

endmodule

bind injector_pulse_fuel_gauge_top ipfg_checker u_ipfg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for injector_pulse_fuel_gauge_top: directed and random tick streams.
// Predicts every reading from its own copy of the gauge state and compares beat by beat.
// Depends on ipfg_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CountW   = ipfg_pkg::CountW;
  localparam int unsigned VolumeW  = ipfg_pkg::VolumeW;
  localparam int unsigned CoeffW   = ipfg_pkg::CoeffW;
  localparam int unsigned CfgIdxW  = ipfg_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = ipfg_pkg::CfgDataW;
  localparam int unsigned InDataW  = ipfg_pkg::InDataW;
  localparam int unsigned OutDataW = ipfg_pkg::OutDataW;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam logic [CountW-1:0] One = 1;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [CountW-1:0]  pulses;
    logic [CountW-1:0]  open_total;
    logic [CountW-1:0]  used;
    logic [VolumeW-1:0] left;
    logic               reserve;
  } gauge_reading_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // gauge state as seen by the predictor
  logic [CountW-1:0]  tick_now = '0;
  logic [CountW-1:0]  open_stamp = '0;
  logic               inj_open = 1'b0;
  logic [CountW-1:0]  pulse_count = '0;
  logic [CountW-1:0]  open_sum = '0;
  logic [CoeffW-1:0]  coeff_reg = ipfg_pkg::CoeffReset;
  logic [VolumeW-1:0] tank_reg = ipfg_pkg::TankReset;
  logic [VolumeW-1:0] reserve_reg = ipfg_pkg::ReserveReset;

  gauge_reading_t expected_readings[$];
  gauge_reading_t got_reading;
  gauge_reading_t want_reading;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  injector_pulse_fuel_gauge_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic gauge_reading_t advance_gauge(input bit low, input bit clr);
    gauge_reading_t r;
    logic [2*CountW-1:0] product;
    if (clr) begin
      pulse_count = '0;
      open_sum = '0;
    end
    if (low && !inj_open) begin
      open_stamp = tick_now;
      inj_open = 1'b1;
      pulse_count = pulse_count + One;
    end else if (!low && inj_open) begin
      open_sum = open_sum + (tick_now - open_stamp);
      inj_open = 1'b0;
    end
    tick_now = tick_now + One;
    product = {{CountW{1'b0}}, open_sum} * {{(2*CountW-CoeffW){1'b0}}, coeff_reg};
    r.pulses = pulse_count;
    r.open_total = open_sum;
    r.used = product[2*CountW-1:CountW];
    r.left = (r.used >= CountW'(tank_reg)) ? '0 : VolumeW'(CountW'(tank_reg) - r.used);
    r.reserve = (r.left <= reserve_reg);
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_reading.pulses     = m_axis_tdata[31:0];
      got_reading.open_total = m_axis_tdata[63:32];
      got_reading.used       = m_axis_tdata[95:64];
      got_reading.left       = m_axis_tdata[115:96];
      got_reading.reserve    = m_axis_tdata[116];
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want_reading = expected_readings.pop_front();
        check_field("pulses", want_reading.pulses, got_reading.pulses);
        check_field("open_total_us", want_reading.open_total, got_reading.open_total);
        check_field("used_ml", want_reading.used, got_reading.used);
        check_field("left_ml", 32'(want_reading.left), 32'(got_reading.left));
        check_field("on_reserve", 32'(want_reading.reserve), 32'(got_reading.reserve));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_tick(input bit low, input bit clr);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= InDataW'({clr, low});
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    expected_readings.push_back(advance_gauge(low, clr));
  endtask

  // drop valid, wait for every reading, then let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    unique case (idx)
      ipfg_pkg::RegCoeff:   coeff_reg = val;
      ipfg_pkg::RegTank:    tank_reg = val[VolumeW-1:0];
      ipfg_pkg::RegReserve: reserve_reg = val[VolumeW-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
  endtask

  task automatic test_open_close();
    settle();
    write_reg(ipfg_pkg::RegCoeff, 32'hFFFF_FFFF);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_clear();
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_volume_limits();
    settle();
    write_reg(ipfg_pkg::RegTank, '0);
    write_reg(ipfg_pkg::RegReserve, '0);
    send_tick(1'b0, 1'b0);
    settle();
    write_reg(ipfg_pkg::RegTank, CfgDataW'(20'hF_FFFF));
    write_reg(ipfg_pkg::RegReserve, CfgDataW'(20'hF_FFFF));
    send_tick(1'b0, 1'b0);
    settle();
    write_reg(ipfg_pkg::RegTank, CfgDataW'(100));
    write_reg(ipfg_pkg::RegReserve, CfgDataW'(500));
    send_tick(1'b1, 1'b0);
    settle();
    write_reg(RegUnused, 32'hFFFF_FFFF);
    send_tick(1'b0, 1'b0);
    settle();
    write_reg(ipfg_pkg::RegCoeff, '0);
    write_reg(ipfg_pkg::RegTank, CfgDataW'(20'hF_FFFF));
    write_reg(ipfg_pkg::RegReserve, '0);
    send_tick(1'b0, 1'b0);
  endtask

  // mostly whole pulses with random lengths, some random noise ticks
  task automatic run_traffic(input int n_ticks);
    int sent;
    int run_len;
    sent = 0;
    while (sent < n_ticks) begin
      if ($urandom_range(99) < 80) begin
        run_len = ($urandom_range(19) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 10);
        repeat (run_len) begin
          send_tick(1'b1, $urandom_range(99) < 3);
          sent++;
        end
        run_len = $urandom_range(1, 10);
        repeat (run_len) begin
          send_tick(1'b0, $urandom_range(99) < 3);
          sent++;
        end
      end else begin
        run_len = $urandom_range(1, 8);
        repeat (run_len) begin
          send_tick(1'($urandom_range(1)), $urandom_range(99) < 20);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input logic [CfgDataW-1:0] coeff,
                                   input logic [CfgDataW-1:0] tank,
                                   input logic [CfgDataW-1:0] reserve);
    settle();
    write_reg(ipfg_pkg::RegCoeff, coeff);
    write_reg(ipfg_pkg::RegTank, tank);
    write_reg(ipfg_pkg::RegReserve, reserve);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    run_traffic(440);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_open_close();
    test_clear();
    test_volume_limits();
    test_random_phase(0, 0, $urandom() | 32'hC000_0000, $urandom_range(20, 300),
                      $urandom_range(0, 300));
    test_random_phase(61, 0, $urandom(), $urandom_range(0, 200), $urandom_range(0, 1048575));
    test_random_phase(0, 61, 32'hFFFF_FFFF, 32'h000F_FFFF, $urandom_range(1048000, 1048575));
    test_random_phase(35, 35, $urandom() | 32'h8000_0000, $urandom_range(50, 400),
                      $urandom_range(0, 400));
    settle();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
